### src/hsv_to_rgb_converter_unit_defines.svh
// Assertion macros shared by the HSV to RGB converter RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define HSV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsv_to_rgb: same-cycle check failed");

`define HSV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsv_to_rgb: next-cycle check failed");

`else

`define HSV_ASSERT_IMPL(lbl, ante, cons)

`define HSV_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### src/hsvrgb_pkg.sv
// Types and constants of the HSV to RGB converter pipeline.
// Used by every module of the block; depends on nothing.
package hsvrgb_pkg;

  // Fractional bits of saturation and value (1.0 is 1 << FRAC_BITS).
  localparam int FRAC_BITS = 12;

  localparam int HUE_W  = 16;
  localparam int LVL_W  = 13;
  localparam int CH_W   = 8;
  localparam int ERR_W  = 2;
  localparam int SECT_W = 3;
  localparam int DIST_W = 12;
  localparam int NUM_SECTORS = 6;
  localparam int NUM_CH = 3;

  localparam logic [HUE_W-1:0] HUE_SIXTY = 16'd3840;
  localparam logic [HUE_W-1:0] HUE_FULL  = 16'd23040;
  localparam logic [31:0]      HSV_ONE   = 32'd1 << FRAC_BITS;

  // s*v product, and s*v times a hue distance of up to 3840.
  localparam int SV_W   = 2 * LVL_W;
  localparam int PROD_W = SV_W + DIST_W;
  // Channel numerator over the denominator ONE*ONE*3840.
  localparam int NUM_W  = (LVL_W + 12 + FRAC_BITS > PROD_W) ?
                          (LVL_W + 12 + FRAC_BITS) : PROD_W;
  // 255*N plus half the denominator; the denominator is 15 << SCALE_SHIFT.
  localparam int SCALE_SHIFT = 2 * FRAC_BITS + 8;
  localparam int Q_W = 12;
  localparam int Y_W = (NUM_W + 9 > SCALE_SHIFT + Q_W) ? (NUM_W + 9) : (SCALE_SHIFT + Q_W);
  localparam logic [Y_W-1:0] ROUND_HALF = Y_W'(64'd15 << (2 * FRAC_BITS + 7));
  // Division by 15 for values below 2**16: multiply by 0x8889 and shift by 19.
  localparam int RECIP_W = 16;
  localparam logic [RECIP_W-1:0] RECIP_15 = 16'h8889;
  localparam int RECIP_SHIFT = 19;
  localparam int QUOT_W = Q_W + RECIP_W - RECIP_SHIFT;
  localparam logic [QUOT_W-1:0] CH_MAX = QUOT_W'(255);

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_HUE  = 2'd1,
    ERR_SAT  = 2'd2,
    ERR_VAL  = 2'd3
  } range_err_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_angle;
    logic [LVL_W-1:0] sat_level;
    logic [LVL_W-1:0] bright_level;
  } hsv_word_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [ERR_W-1:0] range_error;
  } rgb_word_t;

  // Result of the hue front end.
  typedef struct packed {
    range_err_t        err;
    logic [SECT_W-1:0] sector;
    logic [DIST_W-1:0] hue_dist;
    logic [LVL_W-1:0]  sat;
    logic [LVL_W-1:0]  val;
  } front_t;

  // Per-channel numerators, index 0 red, 1 green, 2 blue.
  typedef struct packed {
    range_err_t                    err;
    logic [NUM_CH-1:0][NUM_W-1:0]  num;
  } chroma_t;

endpackage

### src/hsvrgb_front.sv
// Hue front end: range checks, full-circle fold, sector and hue distance.
// Depends on hsvrgb_pkg.
module hsvrgb_front
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      load,
  input  hsv_word_t pix,
  output front_t    front
);

  range_err_t        err;
  logic [HUE_W-1:0]  hue;
  logic [SECT_W-1:0] sector;
  logic [HUE_W-1:0]  base;
  logic [HUE_W-1:0]  pos;
  logic [HUE_W-1:0]  hue_dist;

  always_comb begin
    if (pix.hue_angle > HUE_FULL) begin
      err = ERR_HUE;
    end else if (32'(pix.sat_level) > HSV_ONE) begin
      err = ERR_SAT;
    end else if (32'(pix.bright_level) > HSV_ONE) begin
      err = ERR_VAL;
    end else begin
      err = ERR_NONE;
    end

    // A hue of exactly 360 degrees is the same as zero.
    hue = (pix.hue_angle == HUE_FULL) ? '0 : pix.hue_angle;

    sector = '0;
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (hue >= HUE_W'(k * 3840)) begin
        sector = SECT_W'(k);
      end
    end

    // Position within the current 120-degree pair of sectors.
    if (sector >= SECT_W'(4)) begin
      base = HUE_W'(4 * 3840);
    end else if (sector >= SECT_W'(2)) begin
      base = HUE_W'(2 * 3840);
    end else begin
      base = '0;
    end
    pos      = hue - base;
    hue_dist = (pos >= HUE_SIXTY) ? (pos - HUE_SIXTY) : (HUE_SIXTY - pos);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      front.err      <= err;
      front.sector   <= sector;
      front.hue_dist <= hue_dist[DIST_W-1:0];
      front.sat      <= pix.sat_level;
      front.val      <= pix.bright_level;
    end
  end

endmodule

### src/hsvrgb_chroma.sv
// Chroma stages: s*v, the x term and the per-channel numerators.
// Depends on hsvrgb_pkg; three register stages.
module hsvrgb_chroma
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  logic [2:0] load,
  input  front_t     front,
  output chroma_t    chroma
);

  typedef enum logic [1:0] {
    ROLE_C,
    ROLE_X,
    ROLE_Z
  } role_t;

  range_err_t        s2_err;
  logic [SECT_W-1:0] s2_sector;
  logic [DIST_W-1:0] s2_dist;
  logic [LVL_W-1:0]  s2_val;
  logic [SV_W-1:0]   s2_sv;

  range_err_t        s3_err;
  logic [SECT_W-1:0] s3_sector;
  logic [PROD_W-1:0] s3_px;
  logic [PROD_W-1:0] s3_pc;
  logic [NUM_W-1:0]  s3_base;

  role_t [NUM_CH-1:0]           role;
  logic [NUM_CH-1:0][NUM_W-1:0] num;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s2_err    <= front.err;
      s2_sector <= front.sector;
      s2_dist   <= front.hue_dist;
      s2_val    <= front.val;
      s2_sv     <= SV_W'(front.sat) * SV_W'(front.val);
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      s3_err    <= s2_err;
      s3_sector <= s2_sector;
      s3_px     <= PROD_W'(s2_sv) * PROD_W'(s2_dist);
      s3_pc     <= (PROD_W'(s2_sv) << 12) - (PROD_W'(s2_sv) << 8);
      s3_base   <= ((NUM_W'(s2_val) << 12) - (NUM_W'(s2_val) << 8)) << FRAC_BITS;
    end
  end

  // Each channel is v*ONE*3840 less nothing (chroma), less s*v*dist (x),
  // or less s*v*3840 (the zero channel), all over ONE*ONE*3840.
  always_comb begin
    unique case (s3_sector)
      3'd0:    role = '{ROLE_Z, ROLE_X, ROLE_C};
      3'd1:    role = '{ROLE_Z, ROLE_C, ROLE_X};
      3'd2:    role = '{ROLE_X, ROLE_C, ROLE_Z};
      3'd3:    role = '{ROLE_C, ROLE_X, ROLE_Z};
      3'd4:    role = '{ROLE_C, ROLE_Z, ROLE_X};
      default: role = '{ROLE_X, ROLE_Z, ROLE_C};
    endcase
    for (int ch = 0; ch < NUM_CH; ch++) begin
      case (role[ch])
        ROLE_C:  num[ch] = s3_base;
        ROLE_X:  num[ch] = s3_base - NUM_W'(s3_px);
        default: num[ch] = s3_base - NUM_W'(s3_pc);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load[2]) begin
      chroma.err <= s3_err;
      chroma.num <= num;
    end
  end

endmodule

### src/hsvrgb_scale.sv
// Output scaling: times 255, round half up, divide, clamp, zero on error.
// Depends on hsvrgb_pkg; two register stages, the second is the output word.
module hsvrgb_scale
  import hsvrgb_pkg::*;
(
  input  logic       clk,
  input  logic [1:0] load,
  input  chroma_t    chroma,
  output rgb_word_t  rgb
);

  range_err_t                         s5_err;
  logic [NUM_CH-1:0][Q_W-1:0]         s5_q;
  logic [NUM_CH-1:0][Y_W-1:0]         y;
  logic [NUM_CH-1:0][Q_W+RECIP_W-1:0] prod;
  logic [NUM_CH-1:0][QUOT_W-1:0]      quot;
  logic [NUM_CH-1:0][CH_W-1:0]        chan;

  // The denominator is 15 << SCALE_SHIFT: shift first, then divide by 15.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      y[ch] = (Y_W'(chroma.num[ch]) << 8) - Y_W'(chroma.num[ch]) + ROUND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (load[0]) begin
      s5_err <= chroma.err;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s5_q[ch] <= y[ch][SCALE_SHIFT +: Q_W];
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = (Q_W + RECIP_W)'(s5_q[ch]) * (Q_W + RECIP_W)'(RECIP_15);
      quot[ch] = prod[ch][RECIP_SHIFT +: QUOT_W];
      if (s5_err != ERR_NONE) begin
        chan[ch] = '0;
      end else if (quot[ch] > CH_MAX) begin
        chan[ch] = CH_MAX[CH_W-1:0];
      end else begin
        chan[ch] = quot[ch][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load[1]) begin
      rgb.red_out     <= chan[0];
      rgb.green_out   <= chan[1];
      rgb.blue_out    <= chan[2];
      rgb.range_error <= s5_err;
    end
  end

endmodule

### src/hsv_to_rgb_converter_unit.sv
// HSV to RGB converter: a six-stage pipeline that takes one HSV pixel word
// per clock while the output does not stall and returns one RGB word per
// pixel, in order. Hue is in 1/64 degree (0 to 23040, where 23040 counts as
// 0); saturation and value are Q1.12 (0 to 4096). Each channel is computed
// exactly over the common denominator 4096*4096*3840, scaled by 255 and
// rounded half up. A hue, saturation or value out of range (checked in that
// order) gives range_error 1, 2 or 3 and zero color. Throughput is one pixel
// per clock while the output does not stall; the stages are hue decode, the
// s*v multiply, the s*v*distance multiply, the channel numerators, the
// scale-and-round add and the multiply-by-reciprocal divide by 15. Each stage
// holds its word until the next stage can take it, so an output stall only
// stops the input once every stage is full, and empty stages close up behind
// a held result.
module hsv_to_rgb_converter_unit
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      pix_valid,
  output logic      pix_stall,
  input  hsv_word_t pix,
  output logic      rgb_valid,
  input  logic      rgb_stall,
  output rgb_word_t rgb
);

`include "hsv_to_rgb_converter_unit_defines.svh"

  localparam int STAGES = 6;

  // Stage valid bits, stage 1 (hue decode) through stage 6 (output word).
  logic [STAGES:1] stage_valid;
  // A stage loads when it is empty or its word moves on in this cycle.
  logic [STAGES:1] load;

  front_t  front;
  chroma_t chroma;

  always_comb begin
    load[STAGES] = !stage_valid[STAGES] || !rgb_stall;
    for (int i = STAGES - 1; i >= 1; i--) begin
      load[i] = !stage_valid[i] || load[i+1];
    end
  end

  assign pix_stall = !load[1];
  assign rgb_valid = stage_valid[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (load[1]) begin
        stage_valid[1] <= pix_valid;
      end
      for (int i = 2; i <= STAGES; i++) begin
        if (load[i]) begin
          stage_valid[i] <= stage_valid[i-1];
        end
      end
    end
  end

  // Stage 1: range checks and hue sector.
  hsvrgb_front u_front (
    .clk   (clk),
    .load  (load[1]),
    .pix   (pix),
    .front (front)
  );

  // Stages 2 to 4: chroma products and channel numerators.
  hsvrgb_chroma u_chroma (
    .clk    (clk),
    .load   (load[4:2]),
    .front  (front),
    .chroma (chroma)
  );

  // Stages 5 and 6: scaling, rounding and the output word.
  hsvrgb_scale u_scale (
    .clk    (clk),
    .load   (load[6:5]),
    .chroma (chroma),
    .rgb    (rgb)
  );

  // An error word carries no color.
  `HSV_ASSERT_IMPL(a_error_black, rgb_valid && (rgb.range_error != ERR_NONE), (rgb.red_out == '0) && (rgb.green_out == '0) && (rgb.blue_out == '0))
  // The input is held off only when the whole pipeline is full and blocked.
  `HSV_ASSERT_IMPL(a_stall_only_full, pix_stall, (&stage_valid) && rgb_stall)
  // A word in the last compute stage reaches the output when it is free.
  `HSV_ASSERT_NEXT(a_drain, stage_valid[5] && !(rgb_valid && rgb_stall), rgb_valid)

endmodule

### tb/hsv_to_rgb_converter_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the HSV to RGB converter pipeline.
// Depends on hsvrgb_pkg for the pixel and RGB word types and the range codes.
module hsv_to_rgb_converter_unit_test;
  import hsvrgb_pkg::*;

  // Number of random pixel words that follow the directed table.
  localparam int RANDOM_WORDS = 1626;
  // Words offered back to back while the output side is held off.
  localparam int FLOOD_WORDS = 40;
  localparam int FLOOD_HOLD = 60;
  // The pipeline is six stages deep; this is plenty of settle time at the end.
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT = 200000;

  // One row of the directed table. When has_rgb is set the expected word is
  // the one typed into the row; otherwise it comes from the color predictor.
  typedef struct packed {
    hsv_word_t pixel;
    logic      has_rgb;
    rgb_word_t rgb;
  } pixel_case_t;

  localparam int NUM_CASES = 24;
  localparam pixel_case_t PIXEL_CASES [NUM_CASES] = '{
    // Black, white, and the six primary and secondary colors at full s and v.
    '{'{16'd0,     13'd0,    13'd0},    1'b1, '{8'd0,   8'd0,   8'd0,   ERR_NONE}},
    '{'{16'd0,     13'd0,    13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd255, ERR_NONE}},
    '{'{16'd0,     13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0,   ERR_NONE}},
    // A hue of exactly 360 degrees wraps around to pure red.
    '{'{16'd23040, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd0,   ERR_NONE}},
    '{'{16'd7680,  13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd255, 8'd0,   ERR_NONE}},
    '{'{16'd15360, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd0,   8'd255, ERR_NONE}},
    '{'{16'd3840,  13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd255, 8'd0,   ERR_NONE}},
    '{'{16'd11520, 13'd4096, 13'd4096}, 1'b1, '{8'd0,   8'd255, 8'd255, ERR_NONE}},
    '{'{16'd19200, 13'd4096, 13'd4096}, 1'b1, '{8'd255, 8'd0,   8'd255, ERR_NONE}},
    // Middle of every sector, the last hue before 360, and a few rounding cases.
    '{'{16'd1920,  13'd4096, 13'd4096}, 1'b0, '0},
    '{'{16'd5760,  13'd4096, 13'd4096}, 1'b0, '0},
    '{'{16'd9600,  13'd3000, 13'd4096}, 1'b0, '0},
    '{'{16'd13440, 13'd4096, 13'd2500}, 1'b0, '0},
    '{'{16'd17280, 13'd2048, 13'd3000}, 1'b0, '0},
    '{'{16'd21120, 13'd1234, 13'd4000}, 1'b0, '0},
    '{'{16'd23039, 13'd4096, 13'd4096}, 1'b0, '0},
    '{'{16'd1000,  13'd2048, 13'd2048}, 1'b0, '0},
    '{'{16'd1,     13'd1,    13'd1},    1'b0, '0},
    // Out of range fields; the hue check wins over saturation, which wins
    // over value, and the color channels read as zero.
    '{'{16'd23041, 13'd0,    13'd0},    1'b1, '{8'd0,   8'd0,   8'd0,   ERR_HUE}},
    '{'{16'd65535, 13'd8191, 13'd8191}, 1'b1, '{8'd0,   8'd0,   8'd0,   ERR_HUE}},
    '{'{16'd0,     13'd4097, 13'd0},    1'b1, '{8'd0,   8'd0,   8'd0,   ERR_SAT}},
    '{'{16'd0,     13'd8191, 13'd8191}, 1'b1, '{8'd0,   8'd0,   8'd0,   ERR_SAT}},
    '{'{16'd0,     13'd0,    13'd4097}, 1'b1, '{8'd0,   8'd0,   8'd0,   ERR_VAL}},
    '{'{16'd23040, 13'd4096, 13'd8191}, 1'b1, '{8'd0,   8'd0,   8'd0,   ERR_VAL}}
  };

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      pix_valid = 1'b0;
  logic      pix_stall;
  hsv_word_t pix = '0;
  logic      rgb_valid;
  logic      rgb_stall = 1'b0;
  rgb_word_t rgb;

  // Side information that travels with the offered pixel word: whether the
  // directed table typed in the expected RGB word, and that word.
  logic      pix_has_rgb = 1'b0;
  rgb_word_t pix_typed_rgb = '0;

  // Raised by the sender while it floods the input; the receiver answers it
  // once with a long hold-off so that every stage fills and the input stalls.
  logic      flood_phase = 1'b0;
  logic      flood_held = 1'b0;

  rgb_word_t pending_rgb [$];
  int        mismatches = 0;
  int        cycle_count = 0;

  hsv_to_rgb_converter_unit uut (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix       (pix),
    .rgb_valid (rgb_valid),
    .rgb_stall (rgb_stall),
    .rgb       (rgb)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Scales an exact channel fraction num/den to 0..255, rounding half up.
  function automatic logic [CH_W-1:0] round_to_byte(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    q = (num * 64'd255 + den / 64'd2) / den;
    return (q > 64'd255) ? 8'd255 : q[CH_W-1:0];
  endfunction

  // Color predictor. Everything is kept as an exact numerator over the
  // common denominator one*one*3840, so no precision is lost before rounding.
  function automatic rgb_word_t rgb_for_pixel(hsv_word_t p);
    logic [63:0] one, hue, sat, val, sect, pos, hue_dist, ramp, den;
    logic [63:0] sv, c_num, x_num, m_num, r_num, g_num, b_num;
    rgb_word_t   w;
    one = 64'd1 << FRAC_BITS;
    hue = 64'(p.hue_angle);
    sat = 64'(p.sat_level);
    val = 64'(p.bright_level);
    w = '0;
    if (hue > 64'(HUE_FULL)) begin
      w.range_error = ERR_HUE;
    end else if (sat > one) begin
      w.range_error = ERR_SAT;
    end else if (val > one) begin
      w.range_error = ERR_VAL;
    end
    if (w.range_error != ERR_NONE) begin
      return w;
    end
    if (hue == 64'(HUE_FULL)) begin
      hue = 64'd0;
    end
    sect = hue / 64'(HUE_SIXTY);
    pos = hue % (64'd2 * 64'(HUE_SIXTY));
    hue_dist = (pos >= 64'(HUE_SIXTY)) ? pos - 64'(HUE_SIXTY) : 64'(HUE_SIXTY) - pos;
    // The ramp rises from 0 at a primary hue to 3840 at a secondary hue.
    ramp = 64'(HUE_SIXTY) - hue_dist;
    den = one * one * 64'(HUE_SIXTY);
    sv = sat * val;
    c_num = sv * 64'(HUE_SIXTY);
    x_num = sv * ramp;
    m_num = val * one * 64'(HUE_SIXTY) - c_num;
    case (sect)
      64'd0: begin
        r_num = c_num; g_num = x_num; b_num = 64'd0;
      end
      64'd1: begin
        r_num = x_num; g_num = c_num; b_num = 64'd0;
      end
      64'd2: begin
        r_num = 64'd0; g_num = c_num; b_num = x_num;
      end
      64'd3: begin
        r_num = 64'd0; g_num = x_num; b_num = c_num;
      end
      64'd4: begin
        r_num = x_num; g_num = 64'd0; b_num = c_num;
      end
      default: begin
        r_num = c_num; g_num = 64'd0; b_num = x_num;
      end
    endcase
    w.red_out = round_to_byte(r_num + m_num, den);
    w.green_out = round_to_byte(g_num + m_num, den);
    w.blue_out = round_to_byte(b_num + m_num, den);
    return w;
  endfunction

  // Saturation or value in the legal range, with the edges picked often.
  function automatic logic [LVL_W-1:0] random_level();
    int one_lvl;
    one_lvl = int'(HSV_ONE);
    case ($urandom_range(0, 9))
      0: return LVL_W'(0);
      1: return LVL_W'(one_lvl);
      2: return LVL_W'($urandom_range(0, 3));
      3: return LVL_W'(one_lvl - int'($urandom_range(1, 3)));
      default: return LVL_W'($urandom_range(0, one_lvl));
    endcase
  endfunction

  // Most words are legal pixels; the rest break one field or are pure noise
  // so that every input bit toggles.
  function automatic hsv_word_t random_pixel();
    hsv_word_t p;
    int        pick;
    int        one_lvl;
    int        edge_hue;
    one_lvl = int'(HSV_ONE);
    pick = $urandom_range(0, 99);
    p.sat_level = random_level();
    p.bright_level = random_level();
    if ($urandom_range(0, 4) == 0) begin
      // Near a sector boundary, where the ramp and the channel order switch.
      edge_hue = int'(HUE_SIXTY) * int'($urandom_range(0, NUM_SECTORS))
                 + int'($urandom_range(0, 2)) - 1;
      if (edge_hue < 0) begin
        edge_hue = 0;
      end
      if (edge_hue > int'(HUE_FULL)) begin
        edge_hue = int'(HUE_FULL);
      end
      p.hue_angle = HUE_W'(edge_hue);
    end else begin
      p.hue_angle = HUE_W'($urandom_range(0, int'(HUE_FULL)));
    end
    if (pick < 8) begin
      p.hue_angle = HUE_W'($urandom);
      p.sat_level = LVL_W'($urandom);
      p.bright_level = LVL_W'($urandom);
    end else if (pick < 12) begin
      p.hue_angle = HUE_W'($urandom_range(int'(HUE_FULL) + 1, 65535));
    end else if (pick < 16) begin
      p.sat_level = LVL_W'($urandom_range(one_lvl + 1, 8191));
    end else if (pick < 20) begin
      p.bright_level = LVL_W'($urandom_range(one_lvl + 1, 8191));
    end
    return p;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Scoreboard. An accepted pixel word queues its expected RGB word; an
  // accepted RGB word is compared with the oldest one still waiting. The
  // push comes first so that a word accepted on both sides in the same cycle
  // cannot be missed.
  always @(posedge clk) begin
    rgb_word_t want;
    if (!rst) begin
      if (pix_valid && !pix_stall) begin
        pending_rgb.push_back(pix_has_rgb ? pix_typed_rgb : rgb_for_pixel(pix));
      end
      if (rgb_valid && !rgb_stall) begin
        if (pending_rgb.size() == 0) begin
          $error("RGB word with nothing expected: %h", rgb);
          mismatches++;
        end else begin
          want = pending_rgb.pop_front();
          check_field("red_out", want.red_out, rgb.red_out);
          check_field("green_out", want.green_out, rgb.green_out);
          check_field("blue_out", want.blue_out, rgb.blue_out);
          check_field("range_error", want.range_error, rgb.range_error);
        end
      end
    end
  end

  // Receiver. It switches at random between stall patterns: no stall
  // at all, light or heavy random stalls, or a strict alternation. Now and
  // then it holds off for a while, and once it holds off for a long stretch
  // when the sender starts its flood.
  initial begin : receiver
    int hold_left;
    int mode;
    int mode_left;
    hold_left = 0;
    mode = 0;
    mode_left = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (flood_phase && !flood_held) begin
        flood_held = 1'b1;
        hold_left = FLOOD_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rgb_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(5, 60);
          if ($urandom_range(0, 49) == 0) begin
            hold_left = $urandom_range(20, 40);
          end
        end
        mode_left--;
        case (mode)
          0: rgb_stall <= 1'b0;
          1: rgb_stall <= ($urandom_range(0, 3) == 0);
          2: rgb_stall <= ($urandom_range(0, 1) == 0);
          default: rgb_stall <= mode_left[0];
        endcase
      end
      @(posedge clk);
    end
  end

  // Offers one pixel word and holds it until the block accepts it. The
  // valid stays high on return so that the next word can follow directly.
  task automatic offer_pixel(input hsv_word_t w, input logic has_rgb, input rgb_word_t typed);
    pix <= w;
    pix_has_rgb <= has_rgb;
    pix_typed_rgb <= typed;
    pix_valid <= 1'b1;
    @(posedge clk);
    while (pix_stall) @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    pix_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Stops offering until every expected RGB word has come back. It waits on
  // the clock first, so valid is never lowered and raised in the same step.
  task automatic wait_drained();
    pix_valid <= 1'b0;
    do @(posedge clk); while (pending_rgb.size() != 0);
  endtask

  // Sender: reset, the directed table, then random bursts with gaps, one
  // flood against a held-off receiver, and one full drain halfway through.
  initial begin : sender
    int gap;
    int burst_left;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_CASES; i++) begin
      gap = $urandom_range(0, 3);
      if (gap > 1) begin
        idle_sender(gap - 1);
      end
      offer_pixel(PIXEL_CASES[i].pixel, PIXEL_CASES[i].has_rgb, PIXEL_CASES[i].rgb);
    end
    wait_drained();

    burst_left = 0;
    for (int k = 0; k < RANDOM_WORDS; k++) begin
      if (k == RANDOM_WORDS / 2) begin
        wait_drained();
      end
      if (k == RANDOM_WORDS / 4) begin
        flood_phase <= 1'b1;
        for (int f = 0; f < FLOOD_WORDS; f++) begin
          offer_pixel(random_pixel(), 1'b0, '0);
        end
        flood_phase <= 1'b0;
      end
      if (burst_left == 0) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          idle_sender(gap);
        end
        burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      offer_pixel(random_pixel(), 1'b0, '0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rgb.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog for a block that hangs or drops words.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $error("timeout after %0d cycles, %0d RGB words outstanding",
           cycle_count, pending_rgb.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
